// File: src/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg
// Types and constants shared by the 1-Wire bus master timing engine.
// ----------------------------------------------------------------------------
`default_nettype none

package owbm_pkg;

  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 3;

  // Request kinds on the input channel
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_RESET = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  // Operation in progress
  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // Phases of a slot. A bus reset uses PH_END to wait for the line to go high
  // and PH_TAIL for the final wait; byte slots end in PH_END.
  typedef enum logic [2:0] {
    PH_LOW  = 3'd0,
    PH_MID  = 3'd1,
    PH_END  = 3'd2,
    PH_TAIL = 3'd3
  } phase_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESET_LOW   = 3'd0,
    REG_RESET_TAIL  = 3'd1,
    REG_WRITE_LOW   = 3'd2,
    REG_WRITE_HOLD  = 3'd3,
    REG_RECOVERY    = 3'd4,
    REG_READ_LOW    = 3'd5,
    REG_READ_SAMPLE = 3'd6,
    REG_READ_TAIL   = 3'd7
  } cfg_reg_t;

  localparam logic [CFG_DATA_W-1:0] RESET_LOW_DEFAULT   = 10'd480;
  localparam logic [CFG_DATA_W-1:0] RESET_TAIL_DEFAULT  = 10'd420;
  localparam logic [CFG_DATA_W-1:0] WRITE_LOW_DEFAULT   = 10'd1;
  localparam logic [CFG_DATA_W-1:0] WRITE_HOLD_DEFAULT  = 10'd59;
  localparam logic [CFG_DATA_W-1:0] RECOVERY_DEFAULT    = 10'd2;
  localparam logic [CFG_DATA_W-1:0] READ_LOW_DEFAULT    = 10'd2;
  localparam logic [CFG_DATA_W-1:0] READ_SAMPLE_DEFAULT = 10'd8;
  localparam logic [CFG_DATA_W-1:0] READ_TAIL_DEFAULT   = 10'd50;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] reset_low;
    logic [CFG_DATA_W-1:0] reset_tail;
    logic [CFG_DATA_W-1:0] write_low;
    logic [CFG_DATA_W-1:0] write_hold;
    logic [CFG_DATA_W-1:0] recovery;
    logic [CFG_DATA_W-1:0] read_low;
    logic [CFG_DATA_W-1:0] read_sample;
    logic [CFG_DATA_W-1:0] read_tail;
  } timing_cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       drive_high;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_result;
  } owbm_result_t;

endpackage

`default_nettype wire

// File: src/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master
// 1-Wire bus master timing engine with stream input and result channels.
// ----------------------------------------------------------------------------
// Each request on the input channel is a one-microsecond tick or a command
// (bus reset, write byte, read byte); every request yields exactly one
// result giving the bus drive levels for the next microsecond and the
// busy/done status. A command that arrives while one is in progress is
// ignored. The block takes one request per clock while results are accepted:
// a request passes an input register and the state machine into the result
// register, from which its result is offered, and requests keep flowing
// while the result side accepts one per clock. Slot timings are set through
// the configuration channel, which should be written only while idle.
`default_nettype none

module one_wire_bus_master
  import owbm_pkg::*;
#(
  parameter int RESET_SETTLE_TICKS = 10,
  parameter int COUNT_WIDTH        = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input channel
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [15:0]           in_tdata,   // [7:0] data_byte, [8] bus_sample
  input  wire logic [1:0]            in_tuser,   // [1:0] kind
  // Result channel
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [15:0]                out_tdata,  // [0] drive_low, [1] drive_high,
                                                 // [2] busy_res, [3] done_res,
                                                 // [11:4] read_result
  // Configuration channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic         in_valid_r;
  kind_t        in_kind_r;
  logic [7:0]   in_data_r;
  logic         in_sample_r;
  logic         out_valid_r;
  owbm_result_t out_res_r;
  owbm_result_t step_res;
  timing_cfg_t  timing;
  logic         advance;

  assign cfg_ready = 1'b1;

  owbm_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_reg_t'(cfg_index)),
    .wr_data  (cfg_data),
    .timing   (timing)
  );

  // The held request moves on whenever the result register is free or emptying.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_kind_r   <= kind_t'(in_tuser);
      in_data_r   <= in_tdata[7:0];
      in_sample_r <= in_tdata[8];
    end
  end

  owbm_engine #(
    .RESET_SETTLE_TICKS (RESET_SETTLE_TICKS),
    .COUNT_WIDTH        (COUNT_WIDTH)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (advance),
    .kind       (in_kind_r),
    .data_byte  (in_data_r),
    .bus_sample (in_sample_r),
    .timing     (timing),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.read_result, out_res_r.done_res,
                       out_res_r.busy_res, out_res_r.drive_high, out_res_r.drive_low};

endmodule

`default_nettype wire

// File: src/owbm_regs.sv
// ----------------------------------------------------------------------------
// owbm_regs
// Slot timing registers, written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_regs
  import owbm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire cfg_reg_t              wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output timing_cfg_t                timing
);

  timing_cfg_t timing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.reset_low   <= RESET_LOW_DEFAULT;
      timing_r.reset_tail  <= RESET_TAIL_DEFAULT;
      timing_r.write_low   <= WRITE_LOW_DEFAULT;
      timing_r.write_hold  <= WRITE_HOLD_DEFAULT;
      timing_r.recovery    <= RECOVERY_DEFAULT;
      timing_r.read_low    <= READ_LOW_DEFAULT;
      timing_r.read_sample <= READ_SAMPLE_DEFAULT;
      timing_r.read_tail   <= READ_TAIL_DEFAULT;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_RESET_LOW:   timing_r.reset_low   <= wr_data;
        REG_RESET_TAIL:  timing_r.reset_tail  <= wr_data;
        REG_WRITE_LOW:   timing_r.write_low   <= wr_data;
        REG_WRITE_HOLD:  timing_r.write_hold  <= wr_data;
        REG_RECOVERY:    timing_r.recovery    <= wr_data;
        REG_READ_LOW:    timing_r.read_low    <= wr_data;
        REG_READ_SAMPLE: timing_r.read_sample <= wr_data;
        REG_READ_TAIL:   timing_r.read_tail   <= wr_data;
        default: ;
      endcase
    end
  end

  assign timing = timing_r;

endmodule

`default_nettype wire

// File: src/owbm_engine.sv
// ----------------------------------------------------------------------------
// owbm_engine
// Bus state machine: takes one tick or command per step and yields the status.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_engine
  import owbm_pkg::*;
#(
  parameter int RESET_SETTLE_TICKS = 10,
  parameter int COUNT_WIDTH        = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step_en,
  input  wire kind_t       kind,
  input  wire logic [7:0]  data_byte,
  input  wire logic        bus_sample,
  input  wire timing_cfg_t timing,
  output owbm_result_t     res
);

  localparam logic [COUNT_WIDTH-1:0] SETTLE_LEN = COUNT_WIDTH'(RESET_SETTLE_TICKS);

  // Register values are taken modulo 2**COUNT_WIDTH.
  function automatic logic [COUNT_WIDTH-1:0] fit(input logic [CFG_DATA_W-1:0] v);
    logic [COUNT_WIDTH+CFG_DATA_W-1:0] ext;
    ext = {{COUNT_WIDTH{1'b0}}, v};
    return ext[COUNT_WIDTH-1:0];
  endfunction

  op_t                    op_r, op_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [2:0]             bit_r, bit_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic [7:0]             last_read_r, last_read_nxt;

  logic [COUNT_WIDTH-1:0] len;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   phase_end;
  logic                   done;

  always_comb begin
    len = COUNT_WIDTH'(1);
    unique case (op_r)
      OP_RESET: begin
        if (phase_r == PH_LOW)      len = fit(timing.reset_low);
        else if (phase_r == PH_MID) len = SETTLE_LEN;
        else                        len = fit(timing.reset_tail);
      end
      OP_WRITE: begin
        if (phase_r == PH_LOW)      len = fit(timing.write_low);
        else if (phase_r == PH_MID) len = fit(timing.write_hold);
        else                        len = fit(timing.recovery);
      end
      OP_READ: begin
        if (phase_r == PH_LOW)      len = fit(timing.read_low);
        else if (phase_r == PH_MID) len = fit(timing.read_sample);
        else                        len = fit(timing.read_tail);
      end
      default: len = COUNT_WIDTH'(1);
    endcase
  end

  assign cnt_inc   = cnt_r + COUNT_WIDTH'(1);
  // A zero length ends the phase on its first tick, as the count is then one.
  assign phase_end = !(cnt_inc < len);

  always_comb begin
    op_nxt        = op_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    bit_nxt       = bit_r;
    shift_nxt     = shift_r;
    last_read_nxt = last_read_r;
    done          = 1'b0;

    if (kind == KIND_TICK) begin
      if (op_r != OP_IDLE) begin
        if (op_r == OP_RESET && phase_r == PH_END) begin
          // Wait for the line to return high; no timeout.
          if (bus_sample) begin
            phase_nxt = PH_TAIL;
            cnt_nxt   = '0;
          end
        end else begin
          cnt_nxt = cnt_inc;
          if (phase_end) begin
            cnt_nxt = '0;
            if (op_r == OP_RESET) begin
              if (phase_r == PH_LOW) begin
                phase_nxt = PH_MID;
              end else if (phase_r == PH_MID) begin
                phase_nxt = PH_END;
              end else begin
                op_nxt    = OP_IDLE;
                phase_nxt = PH_LOW;
                done      = 1'b1;
              end
            end else begin
              if (op_r == OP_READ && phase_r == PH_MID && bus_sample) begin
                shift_nxt[bit_r] = 1'b1;
              end
              if (phase_r == PH_LOW) begin
                phase_nxt = PH_MID;
              end else if (phase_r == PH_MID) begin
                phase_nxt = PH_END;
              end else if (bit_r == 3'd7) begin
                if (op_r == OP_READ) last_read_nxt = shift_r;
                op_nxt    = OP_IDLE;
                phase_nxt = PH_LOW;
                bit_nxt   = '0;
                done      = 1'b1;
              end else begin
                bit_nxt   = bit_r + 3'd1;
                phase_nxt = PH_LOW;
              end
            end
          end
        end
      end
    end else if (op_r == OP_IDLE) begin
      phase_nxt = PH_LOW;
      cnt_nxt   = '0;
      bit_nxt   = '0;
      shift_nxt = '0;
      unique case (kind)
        KIND_RESET: op_nxt = OP_RESET;
        KIND_WRITE: begin
          op_nxt    = OP_WRITE;
          shift_nxt = data_byte;
        end
        KIND_READ:  op_nxt = OP_READ;
        default:    op_nxt = OP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r        <= OP_IDLE;
      phase_r     <= PH_LOW;
      cnt_r       <= '0;
      bit_r       <= '0;
      shift_r     <= '0;
      last_read_r <= '0;
    end else if (step_en) begin
      op_r        <= op_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      bit_r       <= bit_nxt;
      shift_r     <= shift_nxt;
      last_read_r <= last_read_nxt;
    end
  end

  // The status describes the state after this step.
  always_comb begin
    res.busy_res    = (op_nxt != OP_IDLE);
    res.done_res    = done;
    res.drive_low   = res.busy_res && (phase_nxt == PH_LOW);
    res.drive_high  = (op_nxt == OP_WRITE) && (phase_nxt == PH_MID) && shift_nxt[bit_nxt];
    res.read_result = last_read_nxt;
  end

endmodule

`default_nettype wire

// File: src/owbm_checker.sv
// ----------------------------------------------------------------------------
// owbm_checker
// Port-level checks on the result channel of the 1-Wire bus master.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  // A stalled result must hold.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The master never pulls low and drives high at once.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("bus driven low and high together");

  // Any drive on the bus belongs to a command in progress.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[0] || out_tdata[1]) |-> out_tdata[2])
    else $error("bus driven while not busy");

  // On completion the bus is released and the block is no longer busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> !out_tdata[2] && !out_tdata[1] && !out_tdata[0])
    else $error("completion while busy or driving");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
